// ===== hw/rtl/vra_pkg.sv =====
package vra_pkg;

  // Field widths
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 40;
  localparam int ATTR_W = 16;
  localparam int STAT_W = 3;

  // Table geometry
  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // Configuration register indexes
  localparam int CFG_NUM = 2;
  localparam int CFG_W   = $clog2(CFG_NUM);
  localparam logic [CFG_W-1:0] CFG_POOL_BASE  = CFG_W'(0);
  localparam logic [CFG_W-1:0] CFG_POOL_LIMIT = CFG_W'(1);

  // Request kinds
  localparam logic REQ_BUMP  = 1'b0;
  localparam logic REQ_CLAIM = 1'b1;

  // Result status codes
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_OVERLAP = 3'd1;
  localparam status_t ST_LIMIT   = 3'd2;
  localparam status_t ST_ZERO    = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

  // Overlap probe that walks down the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W:0]   top;
  } probe_t;

  // Region written into one cell
  typedef struct packed {
    logic [ADDR_W-1:0] rstart;
    logic [ADDR_W-1:0] rend;
    logic [SIZE_W-1:0] rsize;
    logic [ATTR_W-1:0] rattr;
  } region_t;

endpackage

// ===== hw/rtl/vra_cell.sv =====
module vra_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            active,
  input  logic            wr_en,
  input  vra_pkg::region_t wr_region,
  input  vra_pkg::probe_t probe_in,
  output vra_pkg::probe_t probe_out
);

  vra_pkg::region_t region;
  logic             clear;

  // Hold the stored region
  always_ff @(posedge clk) begin
    if (wr_en) begin
      region <= wr_region;
    end
  end

  // The probe is clear of this region if it ends before the start or begins at/after the end
  assign clear = ((probe_in.addr < region.rstart) &&
                  (probe_in.top < {1'b0, region.rstart})) ||
                 (probe_in.addr >= region.rend);

  // Advance the probe one cell, folding in this cell's verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
      probe_out.hit   <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.hit   <= probe_in.hit | (probe_in.valid & active & ~clear);
    end
    probe_out.addr <= probe_in.addr;
    probe_out.top  <= probe_in.top;
  end

endmodule

// ===== hw/rtl/virtual_region_allocator.sv =====
// Bump requests: after the input beat is accepted the controller passes through S_CALC
// and S_DECIDE and holds the result in S_RESP. Claim requests also pass S_SCAN, since the
// overlap probe walks the row of region cells one cell per cycle.
// One request in flight: in_ready stays low until out_ready takes the result beat.
// Reset (synchronous, rst high) empties the table and sets pool_base to 0 and
// pool_limit to all ones; stored regions are undefined until written.
module virtual_region_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [vra_pkg::CFG_W-1:0]   cfg_index,
  input  logic [vra_pkg::ADDR_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [vra_pkg::ADDR_W-1:0]  want_address,
  input  logic [vra_pkg::SIZE_W-1:0]  byte_count,
  input  logic [vra_pkg::ATTR_W-1:0]  region_attrs,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vra_pkg::ADDR_W-1:0]  granted_start,
  output logic [vra_pkg::STAT_W-1:0]  status
);

  localparam int N  = vra_pkg::MAX_REGIONS;
  localparam int AW = vra_pkg::ADDR_W;
  localparam int SW = vra_pkg::SIZE_W;
  localparam int PB = vra_pkg::PAGE_BITS;

  vra_pkg::state_t state, state_next;

  logic [AW-1:0]             pool_base;
  logic [AW-1:0]             pool_limit;
  logic [vra_pkg::CNT_W-1:0] count;
  logic [AW-1:0]             last_end;

  logic                      kind_r;
  logic [AW-1:0]             want_r;
  logic [SW-1:0]             size_r;
  logic [vra_pkg::ATTR_W-1:0] attr_r;
  logic [SW:0]               round_r;
  logic [AW-1:0]             start_r;
  logic [AW:0]               end_r;
  logic                      hit_r;

  logic                      launch;
  logic                      decide;
  logic                      table_full;
  vra_pkg::status_t          verdict;
  vra_pkg::probe_t           probe_head;
  vra_pkg::probe_t           probe_chain [N+1];
  vra_pkg::region_t          wr_region;
  logic [SW:0]               rounded;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_limit <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vra_pkg::CFG_POOL_BASE:  pool_base  <= cfg_wdata;
        vra_pkg::CFG_POOL_LIMIT: pool_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vra_pkg::S_IDLE:   if (in_valid) state_next = vra_pkg::S_CALC;
      vra_pkg::S_CALC:   state_next = (kind_r == vra_pkg::REQ_CLAIM) ?
                                      vra_pkg::S_SCAN : vra_pkg::S_DECIDE;
      vra_pkg::S_SCAN:   if (probe_chain[N].valid) state_next = vra_pkg::S_DECIDE;
      vra_pkg::S_DECIDE: state_next = vra_pkg::S_RESP;
      vra_pkg::S_RESP:   if (out_ready) state_next = vra_pkg::S_IDLE;
      default:           state_next = vra_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = (state == vra_pkg::S_IDLE);
    out_valid = (state == vra_pkg::S_RESP);
    launch    = (state == vra_pkg::S_CALC) && (kind_r == vra_pkg::REQ_CLAIM);
    decide    = (state == vra_pkg::S_DECIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Round the size up to whole pages
  assign rounded = (SW+1)'({1'b0, byte_count[SW-1:PB]} +
                           (SW-PB+1)'(|byte_count[PB-1:0])) << PB;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= req_type;
      want_r  <= want_address;
      size_r  <= byte_count;
      attr_r  <= region_attrs;
      round_r <= rounded;
    end
  end

  // Place the region and form its rounded end
  always_ff @(posedge clk) begin
    if (state == vra_pkg::S_CALC) begin
      if (kind_r == vra_pkg::REQ_CLAIM) begin
        start_r <= want_r;
        end_r   <= {1'b0, want_r} + (AW+1)'(round_r);
      end else if (count == '0) begin
        start_r <= pool_base;
        end_r   <= {1'b0, pool_base} + (AW+1)'(round_r);
      end else begin
        start_r <= last_end;
        end_r   <= {1'b0, last_end} + (AW+1)'(round_r);
      end
    end
  end

  // Feed the probe into the first cell
  always_comb begin
    probe_head.valid = launch;
    probe_head.hit   = 1'b0;
    probe_head.addr  = want_r;
    probe_head.top   = {1'b0, want_r} + (AW+1)'(size_r);
  end

  assign probe_chain[0] = probe_head;

  assign wr_region.rstart = start_r;
  assign wr_region.rend   = end_r[AW-1:0];
  assign wr_region.rsize  = size_r;
  assign wr_region.rattr  = attr_r;

  // Row of region cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    vra_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .active    (count > vra_pkg::CNT_W'(i)),
      .wr_en     (decide && (verdict == vra_pkg::ST_OK) &&
                  (count[vra_pkg::IDX_W-1:0] == vra_pkg::IDX_W'(i))),
      .wr_region (wr_region),
      .probe_in  (probe_chain[i]),
      .probe_out (probe_chain[i+1])
    );
  end

  // Hold the overlap verdict when the probe leaves the row
  always_ff @(posedge clk) begin
    if (state == vra_pkg::S_SCAN && probe_chain[N].valid) begin
      hit_r <= probe_chain[N].hit;
    end
  end

  assign table_full = (count == vra_pkg::CNT_W'(N));

  // Decide the request
  always_comb begin
    if (kind_r == vra_pkg::REQ_BUMP) begin
      priority if (end_r > {1'b0, pool_limit}) verdict = vra_pkg::ST_LIMIT;
      else if (size_r == '0)                   verdict = vra_pkg::ST_ZERO;
      else if (table_full)                     verdict = vra_pkg::ST_FULL;
      else                                     verdict = vra_pkg::ST_OK;
    end else begin
      priority if (end_r[AW]) verdict = vra_pkg::ST_LIMIT;
      else if (hit_r)         verdict = vra_pkg::ST_OVERLAP;
      else if (table_full)    verdict = vra_pkg::ST_FULL;
      else                    verdict = vra_pkg::ST_OK;
    end
  end

  // Commit a granted region
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (decide && verdict == vra_pkg::ST_OK) begin
      count <= count + vra_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (decide && verdict == vra_pkg::ST_OK) begin
      last_end <= end_r[AW-1:0];
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (decide) begin
      status        <= verdict;
      granted_start <= (verdict == vra_pkg::ST_OK) ? start_r : '0;
    end
  end

endmodule
